>>> sv/miu_pkg.sv
package miu_pkg;
    localparam int OPERAND_BITS_DEF = 32;
    localparam int INV_BITS = 31;
    localparam int ST_BITS = 3;
    localparam logic [ST_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [ST_BITS-1:0] ST_RANGE    = 3'd1;
    localparam logic [ST_BITS-1:0] ST_NEGMOD   = 3'd2;
    localparam logic [ST_BITS-1:0] ST_COPRIME  = 3'd3;
    localparam logic [ST_BITS-1:0] ST_SMALLMOD = 3'd4;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic mul_step;
        logic update;
        logic finish;
    } miu_cmd_t;

    typedef struct packed {
        logic early;
        logic div_done;
        logic mul_done;
        logic rcur_zero;
    } miu_stat_t;
endpackage

>>> sv/miu_if.sv
interface miu_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [63:0] modulus;
    modport source (output valid, output value, output modulus, input ready);
    modport sink (input valid, input value, input modulus, output ready);
endinterface

interface miu_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] inverse;
    logic [2:0]  status;
    modport source (output valid, output inverse, output status, input ready);
    modport sink (input valid, input inverse, input status, output ready);
endinterface

>>> sv/miu_ctrl.sv
module miu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  miu_pkg::miu_stat_t  stat,
    output miu_pkg::miu_cmd_t   cmd
);
    import miu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV = 3'd2;
    localparam logic [2:0] S_MUL = 3'd3;
    localparam logic [2:0] S_TEST = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.early)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_done)
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (stat.rcur_zero)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.update = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> sv/miu_dp.sv
module miu_dp #(
    parameter int OPERAND_BITS = miu_pkg::OPERAND_BITS_DEF
) (
    input  logic                clk,
    input  logic [63:0]         value,
    input  logic [63:0]         modulus,
    input  miu_pkg::miu_cmd_t   cmd,
    output miu_pkg::miu_stat_t  stat,
    output logic [30:0]         inverse,
    output logic [2:0]          status
);
    import miu_pkg::*;

    localparam int W = OPERAND_BITS - 1;
    localparam int CW = OPERAND_BITS + 1;
    localparam int CNTW = $clog2(W + 1);
    localparam logic [63:0] LIMIT = (64'd1 << W) - 64'd1;

    logic [W-1:0] m_reg, rprev_reg, rcur_reg, q_reg, rem_reg, mag_reg;
    logic signed [CW-1:0] cprev_reg, ccur_reg, prod_reg;
    logic [CNTW-1:0] cnt_reg;
    logic vneg_reg, reduce_reg;
    logic [2:0] st_reg;
    logic [30:0] inv_reg;
    logic signed [CW-1:0] macc_reg;

    logic [63:0] mag;
    logic [2:0] chk;
    logic [W:0] trial;
    logic [W-1:0] rem_sh;
    logic signed [CW-1:0] cfix;
    logic [W-1:0] res_w;
    logic [63:0] res64;

    assign mag = value[63] ? (64'd0 - value) : value;

    always_comb
    begin
        priority if (mag > LIMIT || (!modulus[63] && modulus > LIMIT))
            chk = ST_RANGE;
        else if (modulus[63])
            chk = ST_NEGMOD;
        else if (modulus < 64'd2)
            chk = ST_SMALLMOD;
        else
            chk = ST_OK;
    end

    assign rem_sh = {rem_reg[W-2:0], q_reg[W-1]};
    assign trial = {rem_reg, q_reg[W-1]} - {1'b0, rcur_reg};
    assign cfix = ccur_reg[CW-1] ? (ccur_reg + $signed({2'b00, m_reg})) : ccur_reg;
    assign res_w = vneg_reg ? (m_reg - cfix[W-1:0]) : cfix[W-1:0];
    assign res64 = 64'(res_w);

    assign stat.early = (st_reg != ST_OK);
    assign stat.div_done = (cnt_reg == CNTW'(1));
    assign stat.mul_done = (cnt_reg == CNTW'(1));
    assign stat.rcur_zero = reduce_reg ? 1'b0 : (rem_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            st_reg <= chk;
            inv_reg <= '0;
            m_reg <= modulus[W-1:0];
            mag_reg <= mag[W-1:0];
            vneg_reg <= value[63];
            reduce_reg <= 1'b1;
            rprev_reg <= modulus[W-1:0];
            rcur_reg <= modulus[W-1:0];
            cprev_reg <= '0;
            ccur_reg <= CW'(1);
        end
        if (cmd.div_start)
        begin
            q_reg <= (reduce_reg && !cmd.update) ? mag_reg : (cmd.update ? rcur_reg : rprev_reg);
            rem_reg <= '0;
            cnt_reg <= CNTW'(W);
            if (cmd.update)
            begin
                rprev_reg <= rcur_reg;
                rcur_reg <= rem_reg;
                cprev_reg <= ccur_reg;
                ccur_reg <= cprev_reg - prod_reg;
            end
        end
        else if (cmd.div_step)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
            if (stat.div_done)
            begin
                cnt_reg <= CNTW'(W);
                macc_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
            end
        end
        else if (cmd.mul_step)
        begin
            macc_reg <= (macc_reg <<< 1) + (q_reg[W-1] ? ccur_reg : CW'(0));
            q_reg <= {q_reg[W-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNTW'(1);
            if (stat.mul_done)
            begin
                prod_reg <= reduce_reg ? '0 :
                            ((macc_reg <<< 1) + (q_reg[W-1] ? ccur_reg : CW'(0)));
            end
        end
        if (cmd.mul_step && stat.mul_done && reduce_reg)
        begin
            reduce_reg <= 1'b0;
            rprev_reg <= m_reg;
            rcur_reg <= m_reg;
            cprev_reg <= CW'(1);
            ccur_reg <= '0;
        end
        if (cmd.finish)
        begin
            if (rcur_reg != W'(1))
            begin
                st_reg <= ST_COPRIME;
                inv_reg <= '0;
            end
            else
            begin
                st_reg <= ST_OK;
                inv_reg <= res64[30:0];
            end
        end
    end

    assign inverse = inv_reg;
    assign status = st_reg;
endmodule

>>> sv/modular_inverse_unit.sv
// Channel  Dir  Payload
// in       in   value[63:0] signed, modulus[63:0] signed
// out      out  inverse[30:0], status[2:0]
// One item at a time. The checks come first; each Euclid step then runs a
// restoring divider and a shift-add multiplier and tests the remainder,
// with one extra step for the first reduction of the value.
// Reset clears the controller only. A stalled result holds its value.
module modular_inverse_unit #(
    parameter int OPERAND_BITS = miu_pkg::OPERAND_BITS_DEF
) (
    input logic   clk,
    input logic   rst_n,
    miu_in_if.sink   in_ch,
    miu_out_if.source out_ch
);
    import miu_pkg::*;

    miu_cmd_t  cmd;
    miu_stat_t stat;

    miu_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    miu_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .clk(clk), .value(in_ch.value), .modulus(in_ch.modulus),
        .cmd(cmd), .stat(stat),
        .inverse(out_ch.inverse), .status(out_ch.status)
    );
endmodule

>>> sim/modular_inverse_unit_tb.sv
`timescale 1ns / 100ps

module modular_inverse_unit_tb;
    import miu_pkg::*;

    localparam logic [63:0] OPERAND_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [INV_BITS-1:0] inverse;
        logic [ST_BITS-1:0]  status;
    } inverse_result_t;

    logic clk;
    logic rst_n;

    miu_in_if  in_ch ();
    miu_out_if out_ch ();

    modular_inverse_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    inverse_result_t expected_results[$];
    int unsigned     mismatch_count;
    int unsigned     sent_count;
    int unsigned     checked_count;
    int unsigned     ok_count;
    bit              idle_enable;
    event            hold_start;
    bit              hold_active;
    int unsigned     stall_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic inverse_result_t predict_inverse(logic [63:0] value, logic [63:0] modulus);
        inverse_result_t res;
        logic [63:0]     mag;
        logic [63:0]     r_prev;
        logic [63:0]     r_cur;
        logic [63:0]     r_next;
        logic [63:0]     quot;
        longint          c_prev;
        longint          c_cur;
        longint          c_next;
        res.inverse = '0;
        mag = value[63] ? (64'd0 - value) : value;
        if (mag > OPERAND_LIMIT || (!modulus[63] && modulus > OPERAND_LIMIT))
        begin
            res.status = ST_RANGE;
        end
        else if (modulus[63])
        begin
            res.status = ST_NEGMOD;
        end
        else if (modulus < 64'd2)
        begin
            res.status = ST_SMALLMOD;
        end
        else
        begin
            r_prev = modulus;
            r_cur = mag % modulus;
            c_prev = 0;
            c_cur = 1;
            while (r_cur != 64'd0)
            begin
                quot = r_prev / r_cur;
                r_next = r_prev - quot * r_cur;
                c_next = c_prev - longint'(quot) * c_cur;
                r_prev = r_cur;
                r_cur = r_next;
                c_prev = c_cur;
                c_cur = c_next;
            end
            if (r_prev != 64'd1)
            begin
                res.status = ST_COPRIME;
            end
            else
            begin
                if (c_prev < 0)
                    c_prev = c_prev + longint'(modulus);
                if (value[63])
                    c_prev = longint'(modulus) - c_prev;
                res.inverse = c_prev[INV_BITS-1:0];
                res.status = ST_OK;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Long receiver hold, counted here while the sender keeps offering items.
    always
    begin
        @(hold_start);
        hold_active <= 1'b1;
        repeat (6000) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Receiver: random stalls after each result when gaps are enabled, and ready held low while the long hold runs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                stall_left <= idle_enable ? $urandom_range(0, 15) : 0;
                out_ch.ready <= 1'b0;
            end
            else if (hold_active)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        inverse_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            checked_count++;
            if (expected_results.size() == 0)
            begin
                $display("MISMATCH at %0t: result transfer with nothing expected", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.status == ST_OK)
                    ok_count++;
                if (out_ch.status !== want.status)
                    report_mismatch("status", 64'(out_ch.status), 64'(want.status));
                if (out_ch.inverse !== want.inverse)
                    report_mismatch("inverse", 64'(out_ch.inverse), 64'(want.inverse));
            end
        end
    end

    task automatic send_item(logic [63:0] value, logic [63:0] modulus);
        int unsigned gap;
        gap = idle_enable ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.modulus <= modulus;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_inverse(value, modulus));
        sent_count++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [63:0] random_operand();
        logic [63:0] mag;
        mag = {32'd0, $urandom_range(0, 32'h7FFF_FFFF)};
        return $urandom_range(0, 1) ? (64'd0 - mag) : mag;
    endfunction

    task automatic test_directed();
        idle_enable = 1'b0;
        send_item(64'd3, 64'd7);
        send_item(-64'sd3, 64'd7);
        send_item(64'd1, OPERAND_LIMIT);
        send_item(-64'sd1, OPERAND_LIMIT);
        send_item(64'd0, 64'd7);
        send_item(64'd6, 64'd9);
        send_item(64'd2, 64'd2);
        send_item(64'd1, 64'd2);
        send_item(-64'sd1, 64'd2);
        send_item(64'd100, 64'd7);
        send_item(OPERAND_LIMIT, OPERAND_LIMIT - 1);
        send_item(64'd0 - OPERAND_LIMIT, 64'd2);
        send_item(64'd1134903170, 64'd1836311903);
        send_item(64'd17, OPERAND_LIMIT);
        send_item(OPERAND_LIMIT + 1, 64'd7);
        send_item(MOST_NEGATIVE, 64'd7);
        send_item(64'd5, OPERAND_LIMIT + 1);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'd5, -64'sd7);
        send_item(64'd5, MOST_NEGATIVE);
        send_item(64'd5, 64'd0);
        send_item(64'd5, 64'd1);
        send_item(-64'sd1, 64'd1);
        drain_results();
    endtask

    task automatic test_random(int unsigned count);
        logic [63:0] value;
        logic [63:0] modulus;
        int unsigned kind;
        idle_enable = 1'b1;
        repeat (count)
        begin
            kind = $urandom_range(0, 9);
            value = random_operand();
            if ($urandom_range(0, 1))
                modulus = {32'd0, $urandom_range(2, 32'h7FFF_FFFF)};
            else
                modulus = {32'd0, $urandom_range(2, 1000)};
            case (kind)
                0:
                begin
                    value = {$urandom(), $urandom()};
                    modulus = {$urandom(), $urandom()};
                end
                1: modulus = 64'd0 - {32'd0, $urandom()};
                2: modulus = {63'd0, 1'($urandom_range(0, 1))};
                3: value = value * modulus[7:0] % (OPERAND_LIMIT + 1);
                default: ;
            endcase
            send_item(value, modulus);
        end
        drain_results();
    endtask

    task automatic test_output_hold();
        idle_enable = 1'b0;
        -> hold_start;
        repeat (6)
            send_item(random_operand(), {32'd0, $urandom_range(2, 32'h7FFF_FFFF)});
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.modulus = '0;
        mismatch_count = 0;
        sent_count = 0;
        checked_count = 0;
        ok_count = 0;
        idle_enable = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(150);
        test_output_hold();
        test_random(150);
        $display("Sent %0d operand pairs, checked %0d results, %0d of them invertible.",
                 sent_count, checked_count, ok_count);
        $display("Covered every status code, long output stalls and random gaps.");
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Timeout with %0d results outstanding.", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> modular_inverse_unit.f
sv/miu_pkg.sv
sv/miu_if.sv
sv/miu_ctrl.sv
sv/miu_dp.sv
sv/modular_inverse_unit.sv
sim/modular_inverse_unit_tb.sv
